### hw/rtl/u8u2_pkg.sv
// Shared types and constants of the UTF-8 to UCS-2 decoder.
// No dependencies; used by the decode, serializer and top-level modules.
package u8u2_pkg;

    // Pending multi-byte sequence.
    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_TWO_CONT    = 2'd1,
        PH_THREE_FIRST = 2'd2,
        PH_THREE_LAST  = 2'd3
    } t_phase;

    localparam logic [7:0]  ASCII_MASK  = 8'h80;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_CODE   = 8'h80;
    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE  = 8'hF0;
    localparam logic [7:0]  LEAD5_MASK  = 8'hFC;
    localparam logic [7:0]  LEAD5_CODE  = 8'hF8;
    localparam logic [7:0]  LEAD6_MASK  = 8'hFE;
    localparam logic [7:0]  LEAD6_CODE  = 8'hFC;
    localparam logic [2:0]  SKIP4       = 3'd3;
    localparam logic [2:0]  SKIP5       = 3'd4;
    localparam logic [2:0]  SKIP6       = 3'd5;
    localparam logic [15:0] REPL_CHAR   = 16'h003F;
    localparam int          MAX_RESULTS = 3;

    // All results of one byte. Every result is a replacement '?' except at
    // most one, the main result, which sits at position main_pos.
    typedef struct packed {
        logic [1:0]  cnt;
        logic        main_vld;
        logic [1:0]  main_pos;
        logic [15:0] main_code;
        logic        main_rep;
    } t_bundle;

endpackage

### hw/rtl/u8u2_decode.sv
// Per-byte decode logic and the pending-sequence state of the decoder.
// Depends on u8u2_pkg for the phase type, byte masks and result bundle.
module u8u2_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_eos,
    output u8u2_pkg::t_bundle  o_bundle
);

    u8u2_pkg::t_phase r_phase, n_phase, mid_phase, eff_phase;
    logic [9:0]       r_partial, n_partial, mid_partial;
    logic [2:0]       r_skip, n_skip, mid_skip;

    logic             skipping, is_cont, pre_flush;
    logic             is_ascii, is_lead2, is_lead3, is_lead4, is_lead5, is_lead6;
    logic [1:0]       pre_cnt, eos_cnt;
    logic [15:0]      joined;
    logic [2:0]       total;
    logic             main_vld, main_rep;
    logic [15:0]      main_code;

    assign skipping  = (r_skip != 3'd0);
    assign is_cont   = ((i_byte & u8u2_pkg::CONT_MASK) == u8u2_pkg::CONT_CODE);
    assign pre_flush = !skipping && (r_phase != u8u2_pkg::PH_IDLE) && !is_cont;
    assign eff_phase = u8u2_pkg::t_phase'(pre_flush ? u8u2_pkg::PH_IDLE : r_phase);

    assign is_ascii = ((i_byte & u8u2_pkg::ASCII_MASK) == 8'h00);
    assign is_lead2 = ((i_byte & u8u2_pkg::LEAD2_MASK) == u8u2_pkg::LEAD2_CODE);
    assign is_lead3 = ((i_byte & u8u2_pkg::LEAD3_MASK) == u8u2_pkg::LEAD3_CODE);
    assign is_lead4 = ((i_byte & u8u2_pkg::LEAD4_MASK) == u8u2_pkg::LEAD4_CODE);
    assign is_lead5 = ((i_byte & u8u2_pkg::LEAD5_MASK) == u8u2_pkg::LEAD5_CODE);
    assign is_lead6 = ((i_byte & u8u2_pkg::LEAD6_MASK) == u8u2_pkg::LEAD6_CODE);

    assign joined = {r_partial, i_byte[5:0]};

    // Next state: the flush of an interrupted sequence, then the byte itself, then the end-of-string flush.
    always_comb begin
        mid_phase   = r_phase;
        mid_partial = r_partial;
        mid_skip    = r_skip;
        if (skipping) begin
            mid_skip = r_skip - 3'd1;
        end else begin
            if (pre_flush) begin
                mid_phase   = u8u2_pkg::PH_IDLE;
                mid_partial = '0;
            end
            case (eff_phase)
                u8u2_pkg::PH_IDLE: begin
                    if (is_lead2) begin
                        mid_phase   = u8u2_pkg::PH_TWO_CONT;
                        mid_partial = {5'd0, i_byte[4:0]};
                    end else if (is_lead3) begin
                        mid_phase   = u8u2_pkg::PH_THREE_FIRST;
                        mid_partial = {6'd0, i_byte[3:0]};
                    end else if (is_lead4) begin
                        mid_skip = u8u2_pkg::SKIP4;
                    end else if (is_lead5) begin
                        mid_skip = u8u2_pkg::SKIP5;
                    end else if (is_lead6) begin
                        mid_skip = u8u2_pkg::SKIP6;
                    end
                end
                u8u2_pkg::PH_THREE_FIRST: begin
                    mid_phase   = u8u2_pkg::PH_THREE_LAST;
                    mid_partial = {r_partial[3:0], i_byte[5:0]};
                end
                default: begin
                    mid_phase   = u8u2_pkg::PH_IDLE;
                    mid_partial = '0;
                end
            endcase
        end
        n_phase   = u8u2_pkg::t_phase'(i_eos ? u8u2_pkg::PH_IDLE : mid_phase);
        n_partial = i_eos ? 10'd0 : mid_partial;
        n_skip    = i_eos ? 3'd0 : mid_skip;
    end

    // Results of this byte.
    always_comb begin
        main_vld  = 1'b0;
        main_code = u8u2_pkg::REPL_CHAR;
        main_rep  = 1'b1;
        if (!skipping) begin
            case (eff_phase)
                u8u2_pkg::PH_IDLE: begin
                    if (is_ascii) begin
                        main_vld  = (i_byte != 8'h00);
                        main_code = {8'h00, i_byte};
                        main_rep  = 1'b0;
                    end else if (!is_lead2 && !is_lead3) begin
                        main_vld  = 1'b1;
                    end
                end
                u8u2_pkg::PH_THREE_FIRST: begin
                    main_vld = 1'b0;
                end
                default: begin
                    main_vld  = (joined != 16'h0000);
                    main_code = joined;
                    main_rep  = 1'b0;
                end
            endcase
        end
        pre_cnt = 2'd0;
        if (pre_flush) begin
            pre_cnt = (r_phase == u8u2_pkg::PH_THREE_LAST) ? 2'd2 : 2'd1;
        end
        eos_cnt = 2'd0;
        if (i_eos && (mid_phase != u8u2_pkg::PH_IDLE)) begin
            eos_cnt = (mid_phase == u8u2_pkg::PH_THREE_LAST) ? 2'd2 : 2'd1;
        end
        total = {1'b0, pre_cnt} + {2'b00, main_vld} + {1'b0, eos_cnt};
        o_bundle.cnt       = (total > 3'(u8u2_pkg::MAX_RESULTS)) ?
                             2'(u8u2_pkg::MAX_RESULTS) : total[1:0];
        o_bundle.main_vld  = main_vld;
        o_bundle.main_pos  = pre_cnt;
        o_bundle.main_code = main_code;
        o_bundle.main_rep  = main_rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= u8u2_pkg::PH_IDLE;
            r_partial <= '0;
            r_skip    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_skip    <= n_skip;
        end
    end

endmodule

### hw/rtl/u8u2_serializer.sv
// Result register that hands out the results of one byte one per cycle while the receiver is ready.
// Depends on u8u2_pkg for the result bundle and the replacement character.
module u8u2_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  u8u2_pkg::t_bundle  i_bundle,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_code,
    output logic               o_rep,
    output logic               o_last
);

    logic [1:0]  r_left, r_idx;
    logic        r_main_vld, r_main_rep;
    logic [1:0]  r_main_pos;
    logic [15:0] r_main_code;
    logic        take, on_main;

    assign o_valid    = (r_left != 2'd0);
    assign take       = o_valid && i_ready;
    assign o_can_load = (r_left == 2'd0) || ((r_left == 2'd1) && i_ready);
    assign on_main    = r_main_vld && (r_idx == r_main_pos);
    assign o_code     = on_main ? r_main_code : u8u2_pkg::REPL_CHAR;
    assign o_rep      = on_main ? r_main_rep : 1'b1;
    assign o_last     = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_bundle.cnt;
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_main_vld  <= i_bundle.main_vld;
            r_main_pos  <= i_bundle.main_pos;
            r_main_code <= i_bundle.main_code;
            r_main_rep  <= i_bundle.main_rep;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, r_idx} + {1'b0, r_left}) <= 3'(u8u2_pkg::MAX_RESULTS)))
        else $error("result index runs past the bundle");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("bundle loaded over results still waiting");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_last) |=> o_valid)
        else $error("results of one byte cut short");

    a_main_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_bundle.main_vld) |-> (i_bundle.main_pos < i_bundle.cnt))
        else $error("main result placed outside its bundle");

endmodule

### hw/rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder: input register, decode, result serializer.
// Depends on u8u2_pkg, u8u2_decode and u8u2_serializer.
//
// Usage: UTF-8 bytes enter on the slave stream, one byte per item, with tlast
// marking the last byte of a string. UCS-2 code units leave on the master
// stream, one per item; tuser flags a replacement '?', and tlast marks the
// final result caused by one input byte.
// A byte sits in the input register, where the decode logic reads it
// together with the pending-sequence state. Its results (none to three)
// then move as one bundle into the result register, from which the first
// result is offered to the receiver.
// Throughput is one byte per cycle for bytes with zero or one result while
// the receiver is ready; more results hold the output until each is taken,
// so the result register's one-per-cycle output sets the rate. Bytes that
// yield nothing (NUL, sequence leads, swallowed bytes) step the decoder even
// while results still wait. When the receiver stalls, results hold in the
// result register, the next decoded byte waits in the input register, and
// tready drops once both are full. A synchronous low reset empties both
// registers and clears any pending sequence and swallow count.
module utf8_to_ucs2_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_string
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic        o_m_axis_tuser,   // [0] replaced
    output logic        o_m_axis_tlast    // last_of_run
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_eos;
    logic              step, can_load, load, s_take;
    u8u2_pkg::t_bundle bundle;

    // A byte with no results may step even while the serializer is busy.
    assign step   = r_in_vld && ((bundle.cnt == 2'd0) || can_load);
    assign load   = step && (bundle.cnt != 2'd0);
    assign o_s_axis_tready = !r_in_vld || step;
    assign s_take = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tlast;
        end
    end

    u8u2_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_eos    (r_in_eos),
        .o_bundle (bundle)
    );

    u8u2_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_code     (o_m_axis_tdata),
        .o_rep      (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

endmodule
